// ----- design/sru_pkg.sv -----
// Shared types, constants and table addressing for the subset rank unranker.
// No dependencies; imported by sru_fill, sru_walk and the top level.
package sru_pkg;

    localparam int MAX_SET   = 64;                      // largest set size
    localparam int TBL_DIM   = MAX_SET + 1;             // rows and columns of the triangle
    localparam int TBL_DEPTH = TBL_DIM * TBL_DIM;       // binomial table entries
    localparam int TBL_AW    = $clog2(TBL_DEPTH);       // table address width
    localparam int COEF_W    = 61;                      // widest coefficient C(64,32)
    localparam int RANK_W    = 63;
    localparam int K_W       = $clog2(MAX_SET + 1);     // subset size / set size width
    localparam int POS_W     = $clog2(MAX_SET);         // bit position width
    localparam int MASK_W    = MAX_SET;

    localparam int IN_DATA_W  = ((RANK_W + K_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((MASK_W + 7) / 8) * 8;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_SET_SIZE = 0;                    // register index of set_size

    // Table port request from the fill sequencer
    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] waddr;
        logic [COEF_W-1:0] wdata;
        logic [TBL_AW-1:0] raddr;
    } ram_req_t;

    // Row-major address of C(row, col); column saturates to keep the
    // address inside the table for out-of-range requests.
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [K_W-1:0] row,
                                                   input logic [K_W-1:0] col);
        logic [K_W-1:0] col_sat;
        col_sat = (col > K_W'(MAX_SET)) ? K_W'(MAX_SET) : col;
        return TBL_AW'(row) * TBL_AW'(TBL_DIM) + TBL_AW'(col_sat);
    endfunction

endpackage

// ----- design/sru_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/sru_fill.sv -----
// Pascal triangle fill sequencer: after reset writes every table entry,
// one per cycle, reading the previous row. Depends on sru_pkg.
module sru_fill (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [sru_pkg::COEF_W-1:0] rd_data,
    output sru_pkg::ram_req_t     req,
    output logic                  done
);
    import sru_pkg::*;

    logic [K_W-1:0]    row_reg, row_next;
    logic [K_W-1:0]    col_reg, col_next;
    logic [TBL_AW-1:0] addr_reg, addr_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;

    // write stage, in the cycle after the read issue
    logic              wvld_reg;
    logic [K_W-1:0]    wrow_reg;
    logic [K_W-1:0]    wcol_reg;
    logic [TBL_AW-1:0] waddr_reg;
    logic [COEF_W-1:0] prev_reg;        // C(i-1, j-1) from last read
    logic [COEF_W-1:0] wdata;
    logic              last_col;

    assign last_col = (col_reg == K_W'(MAX_SET));

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        addr_next = addr_reg;
        run_next  = run_reg;
        done_next = done_reg;
        if (run_reg)
        begin
            addr_next = addr_reg + TBL_AW'(1);
            if (last_col)
            begin
                col_next = '0;
                if (row_reg == K_W'(MAX_SET))
                begin
                    run_next = 1'b0;
                end
                else
                begin
                    row_next = row_reg + K_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + K_W'(1);
            end
        end
        if (wvld_reg && (wrow_reg == K_W'(MAX_SET)) && (wcol_reg == K_W'(MAX_SET)))
        begin
            done_next = 1'b1;
        end
    end

    // C(i,j) = C(i-1,j-1) + C(i-1,j); row 0 is the unit row
    always_comb
    begin
        if (wrow_reg == '0)
        begin
            wdata = COEF_W'(wcol_reg == '0);
        end
        else
        begin
            wdata = ((wcol_reg == '0) ? '0 : prev_reg) + rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            addr_reg <= '0;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            wvld_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            addr_reg <= addr_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            wvld_reg <= run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wrow_reg  <= row_reg;
        wcol_reg  <= col_reg;
        waddr_reg <= addr_reg;
        if (wvld_reg)
        begin
            prev_reg <= rd_data;
        end
    end

    always_comb
    begin
        req.we    = wvld_reg;
        req.waddr = waddr_reg;
        req.wdata = wdata;
        req.raddr = (row_reg == '0) ? addr_reg : addr_reg - TBL_AW'(TBL_DIM);
    end

    assign done = done_reg;

    a_no_write_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !wvld_reg && !run_reg)
        else $error("table write after fill done");

    a_done_stays: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("fill done dropped");

    a_addr_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> addr_reg == tbl_addr(row_reg, col_reg))
        else $error("fill address out of step with row/column");

endmodule

// ----- design/sru_walk.sv -----
// Unranking walk: range check, then one compare/subtract per position
// with the next table read issued from this cycle's decision. Depends on sru_pkg.
module sru_walk (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       enable,
    input  logic [sru_pkg::K_W-1:0]    set_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sru_pkg::RANK_W-1:0] in_rank,
    input  logic [sru_pkg::K_W-1:0]    in_k,
    input  logic [sru_pkg::COEF_W-1:0] rd_data,
    output logic [sru_pkg::TBL_AW-1:0] raddr,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [sru_pkg::MASK_W-1:0] res_mask,
    output logic                       res_err
);
    import sru_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DONE  = 4'b1000
    } walk_state_t;

    walk_state_t       state_reg, state_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [K_W-1:0]    n_reg, n_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              err_reg, err_next;

    logic              accept;
    logic              take;
    logic [K_W-1:0]    k_dec;
    logic [RANK_W-1:0] coef;

    assign in_ready = (state_reg == ST_IDLE) && enable;
    assign accept   = in_valid && in_ready;
    assign coef     = RANK_W'(rd_data);
    assign take     = (rank_reg >= coef);
    assign k_dec    = k_reg - K_W'(take);

    always_comb
    begin
        state_next = state_reg;
        rank_next  = rank_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        mask_next  = mask_reg;
        err_next   = err_reg;
        raddr      = tbl_addr(set_n, in_k);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rank_next  = in_rank;
                    k_next     = in_k;
                    n_next     = set_n;
                    mask_next  = '0;
                    err_next   = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // rd_data is C(n, k); start at position n-1
                raddr    = tbl_addr((n_reg == '0) ? '0 : n_reg - K_W'(1), k_reg);
                pos_next = POS_W'(n_reg - K_W'(1));
                if ((k_reg > n_reg) || take)
                begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (k_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // rd_data is C(pos, k)
                raddr = tbl_addr((pos_reg == '0) ? '0 : K_W'(pos_reg) - K_W'(1), k_dec);
                k_next = k_dec;
                if (take)
                begin
                    rank_next = rank_reg - coef;
                    mask_next = mask_reg | (MASK_W'(1) << pos_reg);
                end
                if ((k_dec == '0) || (pos_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next = pos_reg - POS_W'(1);
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
        k_reg    <= k_next;
        n_reg    <= n_next;
        pos_reg  <= pos_next;
        mask_reg <= mask_next;
        err_reg  <= err_next;
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res_mask  = mask_reg;
    assign res_err   = err_reg;

    a_err_zero_mask: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_err |-> res_mask == '0)
        else $error("error result with nonzero mask");

    a_all_placed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_err |-> k_reg == '0)
        else $error("walk ended with elements left to place");

    a_walk_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> k_reg != '0)
        else $error("walk running with empty subset");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_mask) && $stable(res_err))
        else $error("result changed before it was taken");

endmodule

// ----- design/subset_rank_unranker_core.sv -----
// Top level of the subset rank unranker: config register, binomial table RAM,
// fill sequencer, walk engine and output register. Depends on sru_pkg,
// sru_ram, sru_fill, sru_walk.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+--------------------------------------
//  s_*       | in        | s_tvalid / s_tready     | s_tdata: rank_index, subset_size
//  m_*       | out       | m_tvalid / m_tready     | m_tdata: subset_mask; m_tuser: error
//  APB       | in/out    | psel & penable, pready  | set_size at byte address 0
//
// An accepted item is range checked, then walks its positions (from set_size-1
// down to the lowest set bit, at most 64), one table read per position on the
// single RAM read port, before its result is ready.
// After reset the Pascal triangle is built, 4225 entries at one per cycle;
// s_tready stays low until it is done.
// One transaction is in flight at a time; the next one is taken as soon as the
// finished result has moved to the output register, which may still stall.
module subset_rank_unranker_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sru_pkg::IN_DATA_W-1:0]     s_tdata,   // [62:0] rank_index, [69:63] subset_size
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sru_pkg::OUT_DATA_W-1:0]    m_tdata,   // [63:0] subset_mask
    output logic                              m_tuser,   // [0] rank_error
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sru_pkg::PADDR_W-1:0]       paddr,
    input  logic [sru_pkg::PDATA_W-1:0]       pwdata,
    output logic [sru_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import sru_pkg::*;

    // ---------------- configuration register ----------------
    logic [K_W-1:0] set_size_reg;
    logic [K_W-1:0] set_n;          // saturated set size
    logic           reg_hit;
    logic           cfg_wr;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_SET_SIZE));
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? PDATA_W'(set_size_reg) : '0;
    assign set_n   = (set_size_reg > K_W'(MAX_SET)) ? K_W'(MAX_SET) : set_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg <= K_W'(MAX_SET);
        end
        else if (cfg_wr)
        begin
            set_size_reg <= pwdata[K_W-1:0];
        end
    end

    // ---------------- binomial table ----------------
    ram_req_t          fill_req;
    logic              fill_done;
    logic [COEF_W-1:0] tbl_rdata;
    logic [TBL_AW-1:0] walk_raddr;
    logic [TBL_AW-1:0] tbl_raddr;

    // fill owns the read port until the triangle is complete
    assign tbl_raddr = fill_done ? walk_raddr : fill_req.raddr;

    sru_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (fill_req.we),
        .waddr (fill_req.waddr),
        .wdata (fill_req.wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sru_fill u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_data (tbl_rdata),
        .req     (fill_req),
        .done    (fill_done)
    );

    // ---------------- walk engine ----------------
    logic              res_valid;
    logic              res_ready;
    logic [MASK_W-1:0] res_mask;
    logic              res_err;

    sru_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (fill_done),
        .set_n     (set_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_rank   (s_tdata[RANK_W-1:0]),
        .in_k      (s_tdata[RANK_W+K_W-1:RANK_W]),
        .rd_data   (tbl_rdata),
        .raddr     (walk_raddr),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_mask  (res_mask),
        .res_err   (res_err)
    );

    // ---------------- output register ----------------
    logic              m_valid_reg;
    logic [MASK_W-1:0] m_mask_reg;
    logic              m_err_reg;

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_mask_reg <= res_mask;
            m_err_reg  <= res_err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_mask_reg);
    assign m_tuser  = m_err_reg;

    a_no_accept_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !fill_done |-> !s_tready)
        else $error("input taken before table fill finished");

    a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> m_tvalid)
        else $error("finished result lost on the way to the output register");

    a_out_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error transaction carries a mask");

endmodule
